// ----- rtl/itra_pkg.sv -----
// itra_pkg: shared types, constants and the digit-to-ASCII map for the
// integer-to-radix ASCII unit. No dependencies.

package itra_pkg;

	localparam int RADIX_W = 6;
	localparam int DIGIT_W = 6;
	localparam int CHAR_W  = 7;
	localparam int LEN_W   = 6;

	typedef logic [RADIX_W-1:0] radix_t;
	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [CHAR_W-1:0]  char_t;
	typedef logic [LEN_W-1:0]   len_t;

	localparam radix_t MIN_RADIX     = radix_t'(2);
	localparam radix_t MAX_RADIX     = radix_t'(36);
	localparam radix_t DECIMAL_RADIX = radix_t'(10);

	localparam char_t CHAR_MINUS  = char_t'(8'h2D);
	localparam char_t CHAR_ZERO   = char_t'(8'h30);
	localparam char_t CHAR_LETTER = char_t'(8'h37);  // 'A' - 10
	localparam char_t CHAR_NONE   = char_t'(0);

	// control into one digit cell
	typedef struct packed {
		logic load;
		logic step;
		logic shift;
	} cell_ctl_t;

	// control into the converter row
	typedef struct packed {
		logic load;
		logic shift;
	} conv_ctl_t;

	// status back from the converter row
	typedef struct packed {
		logic   busy;
		digit_t top;
	} conv_sts_t;

	function automatic char_t digit_char(input digit_t d);
		char_t c;
		if (d < digit_t'(10)) begin
			c = CHAR_ZERO + char_t'(d);
		end else if (d < digit_t'(36)) begin
			c = CHAR_LETTER + char_t'(d);
		end else begin
			c = CHAR_ZERO;
		end
		return c;
	endfunction

endpackage

// ----- rtl/itra_in_if.sv -----
// itra_in_if: request channel (value, radix) with valid/ready.
// Depends on itra_pkg.

interface itra_in_if #(
	parameter int VALUE_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] value;
	itra_pkg::radix_t              radix;

	modport source (output valid, output value, output radix, input ready);
	modport sink   (input valid, input value, input radix, output ready);
endinterface

// ----- rtl/itra_out_if.sv -----
// itra_out_if: character channel (character, last, length, bad_radix) with
// valid/ready. Depends on itra_pkg.

interface itra_out_if;
	logic             valid;
	logic             ready;
	itra_pkg::char_t  character;
	logic             last;
	itra_pkg::len_t   length;
	logic             bad_radix;

	modport source (output valid, output character, output last, output length,
		output bad_radix, input ready);
	modport sink   (input valid, input character, input last, input length,
		input bad_radix, output ready);
endinterface

// ----- rtl/itra_cell.sv -----
// itra_cell: one digit cell of the conversion row; doubles its digit, adds the
// carry in, reduces mod radix and registers the carry out. Depends on itra_pkg.

module itra_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  itra_pkg::cell_ctl_t ctl,
	input  itra_pkg::radix_t   radix,
	input  logic               cin,
	input  logic               en,
	input  itra_pkg::digit_t   shift_in,
	output itra_pkg::digit_t   digit,
	output logic               carry
);

	itra_pkg::digit_t digit_q;
	logic             carry_q;
	logic [itra_pkg::DIGIT_W:0] dbl;
	logic [itra_pkg::DIGIT_W:0] diff;
	logic                       ge;

	assign dbl   = {digit_q, cin};
	assign ge    = dbl >= {1'b0, radix};
	assign diff  = dbl - {1'b0, radix};
	assign digit = digit_q;
	assign carry = carry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= 1'b0;
		end else begin
			carry_q <= ctl.step & en & ge & ~ctl.load;
		end
	end

	always_ff @(posedge clk) begin
		priority if (ctl.load) begin
			digit_q <= '0;
		end else if (ctl.step) begin
			if (en) begin
				digit_q <= ge ? diff[itra_pkg::DIGIT_W-1:0] : dbl[itra_pkg::DIGIT_W-1:0];
			end
		end else if (ctl.shift) begin
			digit_q <= shift_in;
		end else begin
			digit_q <= digit_q;
		end
	end

endmodule

// ----- rtl/itra_conv.sv -----
// itra_conv: bit-serial radix converter; the magnitude shifts in MSB first
// through a skewed row of itra_cell digits, then the row shifts out upward.
// Depends on itra_pkg and itra_cell.

module itra_conv #(
	parameter int VALUE_WIDTH = 32,
	parameter int NW = $clog2(VALUE_WIDTH + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  itra_pkg::conv_ctl_t    ctl,
	input  logic [VALUE_WIDTH-1:0] mag,
	input  itra_pkg::radix_t       radix,
	output itra_pkg::conv_sts_t    sts,
	output logic [NW-1:0]          count
);

	localparam int TW = $clog2(2 * VALUE_WIDTH);

	logic [VALUE_WIDTH-1:0] bits_q;
	itra_pkg::radix_t       radix_q;
	logic [TW-1:0]          step_q;
	logic                   run_q;
	logic [NW-1:0]          count_q;

	itra_pkg::digit_t       digit [VALUE_WIDTH];
	logic [VALUE_WIDTH-1:0] carry;
	logic [VALUE_WIDTH-1:0] cin;
	logic [VALUE_WIDTH-1:0] en;
	itra_pkg::cell_ctl_t    cell_ctl;
	logic                   grow;

	assign cell_ctl.load  = ctl.load;
	assign cell_ctl.step  = run_q;
	assign cell_ctl.shift = ctl.shift;

	genvar gi;
	generate
		for (gi = 0; gi < VALUE_WIDTH; gi++) begin : g_cell
			itra_pkg::digit_t sin;
			if (gi == 0) begin : g_bot
				assign cin[gi] = bits_q[VALUE_WIDTH-1];
				assign sin     = '0;
			end else begin : g_up
				assign cin[gi] = carry[gi-1];
				assign sin     = digit[gi-1];
			end
			assign en[gi] = step_q < TW'(VALUE_WIDTH + gi);
			itra_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (cell_ctl),
				.radix    (radix_q),
				.cin      (cin[gi]),
				.en       (en[gi]),
				.shift_in (sin),
				.digit    (digit[gi]),
				.carry    (carry[gi])
			);
		end
	endgenerate

	// a carry reaching the first unused cell adds one digit
	always_comb begin
		grow = 1'b0;
		for (int j = 1; j < VALUE_WIDTH; j++) begin
			if (count_q == NW'(j) && carry[j-1]) begin
				grow = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			step_q  <= '0;
			count_q <= '0;
		end else if (ctl.load) begin
			run_q   <= 1'b1;
			step_q  <= '0;
			count_q <= NW'(1);
		end else if (run_q) begin
			step_q <= step_q + TW'(1);
			if (step_q == TW'(2 * VALUE_WIDTH - 2)) begin
				run_q <= 1'b0;
			end
			if (grow) begin
				count_q <= count_q + NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			bits_q  <= mag;
			radix_q <= radix;
		end else if (run_q) begin
			bits_q <= bits_q << 1;
		end
	end

	assign sts.busy = run_q;
	assign sts.top  = digit[VALUE_WIDTH-1];
	assign count    = count_q;

	a_top_no_carry: assert property (@(posedge clk) disable iff (!arst_n)
		!carry[VALUE_WIDTH-1])
		else $error("carry out of the top digit cell");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(VALUE_WIDTH))
		else $error("digit count beyond row length");

endmodule

// ----- rtl/integer_to_radix_ascii_unit.sv -----
// integer_to_radix_ascii_unit: top level; sign handling, sequencing and the
// output word register around itra_conv. Depends on itra_pkg, itra_in_if,
// itra_out_if and itra_conv.
//
//   channel  | role   | fields                               | handshake
//   request  | sink   | value, radix                         | valid/ready
//   result   | source | character, last, length, bad_radix  | valid/ready
//
// A conversion runs from the accept cycle through the steps in which the carry
// wavefront crosses the digit cell row and the exit from the run, then shifts
// leading zeros and digits out; a minus sign and result stalls lengthen it.
// A bad radix emits a single bad_radix word. arst_n clears all control state;
// request.ready is high only when idle, and a stalled result word holds.

module integer_to_radix_ascii_unit #(
	parameter int VALUE_WIDTH = 32
) (
	input logic              clk,
	input logic              arst_n,
	itra_in_if.sink          request,
	itra_out_if.source       result
);

	localparam int NW = $clog2(VALUE_WIDTH + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_BAD, S_CONV, S_SKIP, S_SIGN, S_DIGIT
	} state_t;

	state_t                 state_q;
	logic                   neg_q;
	logic [NW-1:0]          cnt_q;
	logic                   res_valid_q;
	itra_pkg::char_t        res_char_q;
	logic                   res_last_q;
	itra_pkg::len_t         res_len_q;
	logic                   res_bad_q;

	itra_pkg::conv_ctl_t    ctl;
	itra_pkg::conv_sts_t    sts;
	logic [NW-1:0]          count;
	logic [VALUE_WIDTH-1:0] raw;
	logic [VALUE_WIDTH-1:0] mag;
	logic                   radix_ok;
	logic                   is_neg;
	logic                   slot_free;
	logic                   emit;
	logic [NW:0]            total;

	assign raw       = request.value;
	assign radix_ok  = request.radix >= itra_pkg::MIN_RADIX &&
		request.radix <= itra_pkg::MAX_RADIX;
	assign is_neg    = request.radix == itra_pkg::DECIMAL_RADIX && raw[VALUE_WIDTH-1];
	assign mag       = is_neg ? (~raw) + VALUE_WIDTH'(1) : raw;
	assign slot_free = !res_valid_q || result.ready;
	assign emit      = slot_free &&
		(state_q == S_BAD || state_q == S_SIGN || state_q == S_DIGIT);
	assign total     = {1'b0, count} + (NW+1)'(neg_q);

	assign ctl.load  = state_q == S_IDLE && request.valid && radix_ok;
	assign ctl.shift = (state_q == S_SKIP && cnt_q != count) ||
		(state_q == S_DIGIT && slot_free);

	itra_conv #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.NW          (NW)
	) u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.mag    (mag),
		.radix  (request.radix),
		.sts    (sts),
		.count  (count)
	);

	assign request.ready    = state_q == S_IDLE;
	assign result.valid     = res_valid_q;
	assign result.character = res_char_q;
	assign result.last      = res_last_q;
	assign result.length    = res_len_q;
	assign result.bad_radix = res_bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			neg_q       <= 1'b0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
			res_char_q  <= itra_pkg::CHAR_NONE;
			res_last_q  <= 1'b0;
			res_len_q   <= '0;
			res_bad_q   <= 1'b0;
		end else begin
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (request.valid) begin
						neg_q   <= is_neg & radix_ok;
						state_q <= radix_ok ? S_CONV : S_BAD;
					end
				end
				S_BAD: begin
					if (slot_free) begin
						res_char_q  <= itra_pkg::CHAR_NONE;
						res_last_q  <= 1'b1;
						res_len_q   <= '0;
						res_bad_q   <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_CONV: begin
					if (!sts.busy) begin
						cnt_q   <= NW'(VALUE_WIDTH);
						state_q <= S_SKIP;
					end
				end
				S_SKIP: begin
					if (cnt_q == count) begin
						state_q <= neg_q ? S_SIGN : S_DIGIT;
					end else begin
						cnt_q <= cnt_q - NW'(1);
					end
				end
				S_SIGN: begin
					if (slot_free) begin
						res_char_q  <= itra_pkg::CHAR_MINUS;
						res_last_q  <= 1'b0;
						res_len_q   <= '0;
						res_bad_q   <= 1'b0;
						state_q     <= S_DIGIT;
					end
				end
				S_DIGIT: begin
					if (slot_free) begin
						res_char_q  <= itra_pkg::digit_char(sts.top);
						res_last_q  <= cnt_q == NW'(1);
						res_len_q   <= (cnt_q == NW'(1)) ? itra_pkg::len_t'(total) : '0;
						res_bad_q   <= 1'b0;
						cnt_q       <= cnt_q - NW'(1);
						if (cnt_q == NW'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SKIP && cnt_q != count) |-> sts.top == '0)
		else $error("nonzero digit dropped as leading zero");

	a_lead_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIGIT && cnt_q == count && count > NW'(1)) |-> sts.top != '0)
		else $error("leading digit is zero");

	a_emit_idle_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SKIP || state_q == S_SIGN || state_q == S_DIGIT) |->
		(!sts.busy && cnt_q != '0))
		else $error("emitting while row busy or empty");

endmodule
